// ----- src/nrsk_pkg.sv -----
// Shared types and constants for the neighbor range and shared key check.
package nrsk_pkg;

  localparam int ID_BITS    = 20;
  localparam int RSIZE_BITS = 7;
  localparam int RANGE_BITS = 19;
  localparam int CFG_BITS   = 19;
  localparam int OPC_BITS   = 2;
  localparam int QDEPTH     = 2;

  localparam logic [6:0]  RING_SIZE_RESET = 7'd8;
  localparam logic [18:0] RANGE_SQ_RESET  = 19'd625;

  // register indexes on the config port
  localparam logic CFG_RING_SIZE = 1'b0;
  localparam logic CFG_RANGE_SQ  = 1'b1;

  // input opcodes
  localparam logic [OPC_BITS-1:0] OPC_OWN_POS = 2'd0;
  localparam logic [OPC_BITS-1:0] OPC_OWN_KEY = 2'd1;
  localparam logic [OPC_BITS-1:0] OPC_HEADER  = 2'd2;
  localparam logic [OPC_BITS-1:0] OPC_NBR_KEY = 2'd3;

  typedef enum logic [1:0] {
    OP_OWN_POS,
    OP_OWN_KEY,
    OP_HEADER,
    OP_NBR_KEY
  } op_e;

  // classified item control, front to back
  typedef struct packed {
    op_e  op;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic [RSIZE_BITS-1:0] ring_size;
    logic [RANGE_BITS-1:0] range_sq;
  } cfg_t;

endpackage

// ----- src/nrsk_if.sv -----
// Valid/ready channel interfaces for input items and verdicts.
interface nrsk_in_if #(
  parameter int COORD_BITS = 9,
  parameter int KEY_BITS   = 16
);
  logic                           valid;
  logic                           ready;
  logic [nrsk_pkg::OPC_BITS-1:0]  opcode;
  logic [COORD_BITS-1:0]          x_coord;
  logic [COORD_BITS-1:0]          y_coord;
  logic [nrsk_pkg::ID_BITS-1:0]   neighbor_id;
  logic [KEY_BITS-1:0]            key_value;
  logic                           last_key;

  modport source (output valid, opcode, x_coord, y_coord, neighbor_id, key_value, last_key,
                  input ready);
  modport sink (input valid, opcode, x_coord, y_coord, neighbor_id, key_value, last_key,
                output ready);
endinterface

interface nrsk_out_if;
  logic                         valid;
  logic                         ready;
  logic [nrsk_pkg::ID_BITS-1:0] echo_id;
  logic                         in_range;
  logic                         key_neighbor;

  modport source (output valid, echo_id, in_range, key_neighbor, input ready);
  modport sink (input valid, echo_id, in_range, key_neighbor, output ready);
endinterface

// ----- src/neighbor_range_and_shared_key_check_top.sv -----
// Top level: config registers, front end classifier queue and back end execution.
// Holds one node's position and key ring and judges candidate neighbors: a header item
// gives the candidate's number and position, neighbor-key items follow, and the key item
// flagged last produces one verdict (in range by exact squared distance, and key neighbor
// when in range and at least one key matched the own ring). The key compare runs against
// all filled ring entries at once, and the range compare finishes the cycle after the
// header. A two-entry queue between the front and back ends and a registered output keep
// input accepts flowing while a verdict waits, so the sustained rate is one item per
// clock if verdicts drain. Configuration must be written only while idle (not enforced).
module neighbor_range_and_shared_key_check_top #(
  parameter int MAX_RING   = 64,
  parameter int KEY_BITS   = 16,
  parameter int COORD_BITS = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [nrsk_pkg::CFG_BITS-1:0] cfg_data_i,
  nrsk_in_if.sink                       in_if,
  nrsk_out_if.source                    out_if
);

  nrsk_pkg::cfg_t               cfg_q;
  logic                         q_valid, q_ready;
  nrsk_pkg::ctl_t               q_ctl;
  logic [COORD_BITS-1:0]        q_x, q_y;
  logic [nrsk_pkg::ID_BITS-1:0] q_id;
  logic [KEY_BITS-1:0]          q_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ring_size <= nrsk_pkg::RING_SIZE_RESET;
      cfg_q.range_sq  <= nrsk_pkg::RANGE_SQ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nrsk_pkg::CFG_RING_SIZE: cfg_q.ring_size <= cfg_data_i[nrsk_pkg::RSIZE_BITS-1:0];
        nrsk_pkg::CFG_RANGE_SQ:  cfg_q.range_sq  <= cfg_data_i[nrsk_pkg::RANGE_BITS-1:0];
      endcase
    end
  end

  nrsk_front #(
    .COORD_BITS(COORD_BITS),
    .KEY_BITS  (KEY_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_ctl_o  (q_ctl),
    .q_x_o    (q_x),
    .q_y_o    (q_y),
    .q_id_o   (q_id),
    .q_key_o  (q_key)
  );

  nrsk_back #(
    .MAX_RING  (MAX_RING),
    .KEY_BITS  (KEY_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_ready_o(q_ready),
    .q_ctl_i  (q_ctl),
    .q_x_i    (q_x),
    .q_y_i    (q_y),
    .q_id_i   (q_id),
    .q_key_i  (q_key),
    .out_if   (out_if)
  );

endmodule

// ----- src/nrsk_front.sv -----
// Front end: accepts input items, classifies the opcode, and queues them for the back end.
module nrsk_front #(
  parameter int COORD_BITS = 9,
  parameter int KEY_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  nrsk_in_if.sink                      in_if,
  output logic                         q_valid_o,
  input  logic                         q_ready_i,
  output nrsk_pkg::ctl_t               q_ctl_o,
  output logic [COORD_BITS-1:0]        q_x_o,
  output logic [COORD_BITS-1:0]        q_y_o,
  output logic [nrsk_pkg::ID_BITS-1:0] q_id_o,
  output logic [KEY_BITS-1:0]          q_key_o
);

  localparam int CNT_BITS = $clog2(nrsk_pkg::QDEPTH + 1);
  localparam int PTR_BITS = $clog2(nrsk_pkg::QDEPTH);

  nrsk_pkg::ctl_t               ctl;
  nrsk_pkg::ctl_t               ctl_q [nrsk_pkg::QDEPTH];
  logic [COORD_BITS-1:0]        x_q   [nrsk_pkg::QDEPTH];
  logic [COORD_BITS-1:0]        y_q   [nrsk_pkg::QDEPTH];
  logic [nrsk_pkg::ID_BITS-1:0] id_q  [nrsk_pkg::QDEPTH];
  logic [KEY_BITS-1:0]          key_q [nrsk_pkg::QDEPTH];

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic                push, pop;

  always_comb begin
    unique case (in_if.opcode)
      nrsk_pkg::OPC_OWN_POS: ctl.op = nrsk_pkg::OP_OWN_POS;
      nrsk_pkg::OPC_OWN_KEY: ctl.op = nrsk_pkg::OP_OWN_KEY;
      nrsk_pkg::OPC_HEADER:  ctl.op = nrsk_pkg::OP_HEADER;
      nrsk_pkg::OPC_NBR_KEY: ctl.op = nrsk_pkg::OP_NBR_KEY;
    endcase
    // only the final neighbor key produces a verdict
    ctl.emit = (in_if.opcode == nrsk_pkg::OPC_NBR_KEY) && in_if.last_key;
  end

  assign in_if.ready = (cnt_q != CNT_BITS'(nrsk_pkg::QDEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != '0);
  assign pop         = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q] <= ctl;
      x_q[wr_ptr_q]   <= in_if.x_coord;
      y_q[wr_ptr_q]   <= in_if.y_coord;
      id_q[wr_ptr_q]  <= in_if.neighbor_id;
      key_q[wr_ptr_q] <= in_if.key_value;
    end
  end

  assign q_ctl_o = ctl_q[rd_ptr_q];
  assign q_x_o   = x_q[rd_ptr_q];
  assign q_y_o   = y_q[rd_ptr_q];
  assign q_id_o  = id_q[rd_ptr_q];
  assign q_key_o = key_q[rd_ptr_q];

endmodule

// ----- src/nrsk_back.sv -----
// Back end: own position and key ring, distance test, key match, and verdict register.
module nrsk_back #(
  parameter int MAX_RING   = 64,
  parameter int KEY_BITS   = 16,
  parameter int COORD_BITS = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nrsk_pkg::cfg_t               cfg_i,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  nrsk_pkg::ctl_t               q_ctl_i,
  input  logic [COORD_BITS-1:0]        q_x_i,
  input  logic [COORD_BITS-1:0]        q_y_i,
  input  logic [nrsk_pkg::ID_BITS-1:0] q_id_i,
  input  logic [KEY_BITS-1:0]          q_key_i,
  nrsk_out_if.source                   out_if
);

  localparam int SZW   = $clog2(MAX_RING + 1);
  localparam int IW    = (MAX_RING > 1) ? $clog2(MAX_RING) : 1;
  localparam int SQW   = 2 * COORD_BITS;
  localparam int SUMW  = SQW + 1;
  localparam int CMPW  = (SUMW > nrsk_pkg::RANGE_BITS) ? SUMW : nrsk_pkg::RANGE_BITS;

  logic [COORD_BITS-1:0]        own_x_q, own_y_q;
  logic [KEY_BITS-1:0]          ring_q [MAX_RING];
  logic [SZW-1:0]               fill_q, fill_d;
  logic [nrsk_pkg::ID_BITS-1:0] cand_id_q;
  logic                         cand_in_range_q;
  logic                         shared_q;
  logic                         pend_q;
  logic [SQW-1:0]               dx2_q, dy2_q;

  logic                         out_valid_q;
  logic [nrsk_pkg::ID_BITS-1:0] out_id_q;
  logic                         out_in_range_q, out_key_nbr_q;

  logic [SZW-1:0]        eff_size, limit;
  logic [IW-1:0]         wr_idx;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQW-1:0]        dx2_d, dy2_d;
  logic [SUMW-1:0]       dist_sq;
  logic                  in_range_now, match, shared_next;
  logic                  pop, do_pos, do_own_key, do_hdr, do_nbr_key;

  assign q_ready_o  = !q_ctl_i.emit || !out_valid_q || out_if.ready;
  assign pop        = q_valid_i && q_ready_o;
  assign do_pos     = pop && (q_ctl_i.op == nrsk_pkg::OP_OWN_POS);
  assign do_own_key = pop && (q_ctl_i.op == nrsk_pkg::OP_OWN_KEY);
  assign do_hdr     = pop && (q_ctl_i.op == nrsk_pkg::OP_HEADER);
  assign do_nbr_key = pop && (q_ctl_i.op == nrsk_pkg::OP_NBR_KEY);

  // ring size 0 acts as 1, oversize clamps to the ring depth
  always_comb begin
    if (cfg_i.ring_size == '0) begin
      eff_size = SZW'(1);
    end else if (32'(cfg_i.ring_size) > MAX_RING) begin
      eff_size = SZW'(MAX_RING);
    end else begin
      eff_size = SZW'(cfg_i.ring_size);
    end
    limit = (fill_q < eff_size) ? fill_q : eff_size;
  end

  // full ring restarts at entry 0
  always_comb begin
    if (fill_q >= eff_size) begin
      wr_idx = '0;
      fill_d = SZW'(1);
    end else begin
      wr_idx = fill_q[IW-1:0];
      fill_d = fill_q + SZW'(1);
    end
  end

  // header: squares registered, sum and compare the cycle after
  always_comb begin
    dx      = (own_x_q >= q_x_i) ? (own_x_q - q_x_i) : (q_x_i - own_x_q);
    dy      = (own_y_q >= q_y_i) ? (own_y_q - q_y_i) : (q_y_i - own_y_q);
    dx2_d   = SQW'(dx) * SQW'(dx);
    dy2_d   = SQW'(dy) * SQW'(dy);
    dist_sq = SUMW'(dx2_q) + SUMW'(dy2_q);
    in_range_now = pend_q ? (CMPW'(dist_sq) <= CMPW'(cfg_i.range_sq)) : cand_in_range_q;
  end

  // compare the neighbor key against every filled ring entry at once
  always_comb begin
    match = 1'b0;
    for (int j = 0; j < MAX_RING; j++) begin
      if ((SZW'(j) < limit) && (ring_q[j] == q_key_i)) begin
        match = 1'b1;
      end
    end
    shared_next = shared_q || match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_x_q         <= '0;
      own_y_q         <= '0;
      fill_q          <= '0;
      cand_id_q       <= '0;
      cand_in_range_q <= 1'b0;
      shared_q        <= 1'b0;
      pend_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      pend_q <= do_hdr;
      if (pend_q) begin
        cand_in_range_q <= in_range_now;
      end
      if (do_pos) begin
        own_x_q <= q_x_i;
        own_y_q <= q_y_i;
      end
      if (do_own_key) begin
        fill_q <= fill_d;
      end
      if (do_hdr) begin
        cand_id_q <= q_id_i;
        shared_q  <= 1'b0;
      end
      if (do_nbr_key) begin
        shared_q <= q_ctl_i.emit ? 1'b0 : shared_next;
      end
      if (do_nbr_key && q_ctl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_own_key) begin
      ring_q[wr_idx] <= q_key_i;
    end
    if (do_hdr) begin
      dx2_q <= dx2_d;
      dy2_q <= dy2_d;
    end
    if (do_nbr_key && q_ctl_i.emit) begin
      out_id_q       <= cand_id_q;
      out_in_range_q <= in_range_now;
      out_key_nbr_q  <= in_range_now && shared_next;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.echo_id      = out_id_q;
  assign out_if.in_range     = out_in_range_q;
  assign out_if.key_neighbor = out_key_nbr_q;

endmodule
